>>> src/lrcf_pkg.sv
`timescale 1ns / 1ps

package lrcf_pkg;

    // Ring geometry
    localparam int RING_PIXELS = 60;
    localparam int HALF_RING   = RING_PIXELS / 2;
    localparam int POS_W       = 6;
    localparam int HOURS_HALF  = 12;

    // Fade
    localparam int DEF_FADE_STEPS = 16;
    localparam int MS_PER_SEC     = 1000;
    localparam int RECIP_SHIFT    = 20;   // fixed-point shift for divide-by-constant

    // Shade endpoints (value = base +/- step * span / FADE_STEPS)
    localparam int SHADE_FAR_LO = 10;
    localparam int SHADE_MID    = 128;
    localparam int SHADE_FULL   = 255;
    localparam int SPAN_FAR     = 118;
    localparam int SPAN_NEAR    = 127;

    // Field widths
    localparam int HOUR_W  = 5;
    localparam int MS_W    = 10;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_COLOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_COLOR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_TRAIL_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_BOTTOM     = 3'd4;

    // Register reset values
    localparam logic [COLOR_W-1:0] RST_MINUTE_COLOR     = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_HOUR_COLOR       = 24'hFF0000;
    localparam logic [COLOR_W-1:0] RST_HOUR_TRAIL_COLOR = 24'h7F0000;
    localparam logic [COLOR_W-1:0] RST_SECOND_COLOR     = 24'h0000FF;

    // What the second hand paints on a pixel
    typedef enum logic [2:0] {
        SEC_NONE,
        SEC_DOT,
        SEC_AHEAD2,
        SEC_AHEAD1,
        SEC_BEHIND1,
        SEC_BEHIND2
    } t_sec_kind;

    typedef struct packed {
        logic [COLOR_W-1:0] base;   // color before the second hand
        t_sec_kind          kind;
    } t_loc;

    // x in 0..119 -> x mod 60
    function automatic logic [POS_W-1:0] ring_wrap(input logic [6:0] x);
        logic [6:0] y;
        y = (x >= 7'(RING_PIXELS)) ? x - 7'(RING_PIXELS) : x;
        return y[POS_W-1:0];
    endfunction

    // rotate by half the ring for bottom mounting
    function automatic logic [POS_W-1:0] ring_place(input logic [POS_W-1:0] x,
                                                    input logic mb);
        return mb ? ring_wrap(7'(x) + 7'(HALF_RING)) : x;
    endfunction

    // (p - q) mod 60
    function automatic logic [POS_W-1:0] ring_dist(input logic [POS_W-1:0] p,
                                                   input logic [POS_W-1:0] q);
        return ring_wrap(7'(p) + 7'(RING_PIXELS) - 7'(q));
    endfunction

    // floor(x / 12) for x <= 65, by 43/512
    function automatic logic [2:0] div12(input logic [6:0] x);
        logic [11:0] prod;
        prod = 12'(x) * 12'd43;
        return prod[11:9];
    endfunction

    function automatic logic [COLOR_W-1:0] cyan(input logic [CHAN_W-1:0] v);
        return {8'h00, v, v};
    endfunction

endpackage

>>> src/led_ring_clock_face_pixel_core.sv
`timescale 1ns / 1ps

// Clock face pixel core for a 60-LED ring.
// Slave stream: one transaction carries the time of day and one ring position;
// master stream: one transaction returns that position's red/green/blue.
// Minute, hour (with trail on black neighbors) and second hand (with four faded
// cyan neighbors driven by the milliseconds) are composed per pixel.
// Config: write-only port, i_cfg_wr_en with i_cfg_index / i_cfg_data; takes
// effect at the next clock edge. Write only while no transaction is in flight.
// Pipeline: input register -> locate (positions, fade-step multiply) ->
// shade (two fade multiplies, color select) -> output register.
// An accepted item moves through the input, locate and output registers in
// turn; master tvalid rises when the output register takes it.
// Throughput: one pixel per cycle while the master side keeps taking results,
// set by the three-stage pipeline with at most one multiplier level per stage.
// Stall: each stage loads when it is empty or its successor moves, so the input
// keeps accepting while empty stages remain behind a held result; after three
// items back up, o_s_axis_tready drops until the master side takes a result.
// Reset (synchronous, active low): pipeline emptied, colors return to
// green minute, red hour, dark red trail, blue second, top mounting.
module led_ring_clock_face_pixel_core #(
    parameter int FADE_STEPS = lrcf_pkg::DEF_FADE_STEPS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [4:0] hour_of_day, [10:5] minute_now, [16:11] second_now,
    // [26:17] milli_now, [32:27] pixel_index, [39:33] zero
    input  logic [lrcf_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // master stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [lrcf_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // config write port
    input  logic                           i_cfg_wr_en,
    input  logic [lrcf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lrcf_pkg::COLOR_W-1:0]   i_cfg_data
);
    import lrcf_pkg::*;

    localparam int STEP_W = (FADE_STEPS > 1) ? $clog2(FADE_STEPS) : 1;
    localparam int ITEM_W = 33;

    // config registers
    logic [COLOR_W-1:0] r_minute_color, r_hour_color, r_hour_trail_color, r_second_color;
    logic               r_mount_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_color     <= RST_MINUTE_COLOR;
            r_hour_color       <= RST_HOUR_COLOR;
            r_hour_trail_color <= RST_HOUR_TRAIL_COLOR;
            r_second_color     <= RST_SECOND_COLOR;
            r_mount_bottom     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MINUTE_COLOR:     r_minute_color     <= i_cfg_data;
                CFG_HOUR_COLOR:       r_hour_color       <= i_cfg_data;
                CFG_HOUR_TRAIL_COLOR: r_hour_trail_color <= i_cfg_data;
                CFG_SECOND_COLOR:     r_second_color     <= i_cfg_data;
                CFG_MOUNT_BOTTOM:     r_mount_bottom     <= i_cfg_data[0];
                default:              ;  // unknown index: ignored
            endcase
        end
    end

    // pipeline stages
    logic              r_in_valid, r_loc_valid, r_out_valid;
    logic [ITEM_W-1:0] r_in_item;
    t_loc              r_loc;
    logic [STEP_W-1:0] r_step;
    logic [COLOR_W-1:0] r_out_color;

    t_loc               n_loc;
    logic [STEP_W-1:0]  n_step;
    logic [COLOR_W-1:0] n_color;

    logic rdy_out, rdy_loc, rdy_in;

    // a stage loads when empty or when its contents move on
    assign rdy_out = !r_out_valid || i_m_axis_tready;
    assign rdy_loc = !r_loc_valid || rdy_out;
    assign rdy_in  = !r_in_valid  || rdy_loc;

    assign o_s_axis_tready = rdy_in;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_color[7:0], r_out_color[15:8], r_out_color[23:16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_loc_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy_in)  r_in_valid  <= i_s_axis_tvalid;
            if (rdy_loc) r_loc_valid <= r_in_valid;
            if (rdy_out) r_out_valid <= r_loc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_in && i_s_axis_tvalid) begin
            r_in_item <= i_s_axis_tdata[ITEM_W-1:0];
        end
        if (rdy_loc && r_in_valid) begin
            r_loc  <= n_loc;
            r_step <= n_step;
        end
        if (rdy_out && r_loc_valid) begin
            r_out_color <= n_color;
        end
    end

    lrcf_locate #(
        .FADE_STEPS (FADE_STEPS)
    ) u_locate (
        .i_hour             (r_in_item[4:0]),
        .i_minute           (r_in_item[10:5]),
        .i_second           (r_in_item[16:11]),
        .i_milli            (r_in_item[26:17]),
        .i_pixel            (r_in_item[32:27]),
        .i_minute_color     (r_minute_color),
        .i_hour_color       (r_hour_color),
        .i_hour_trail_color (r_hour_trail_color),
        .i_mount_bottom     (r_mount_bottom),
        .o_loc              (n_loc),
        .o_step             (n_step)
    );

    lrcf_shade #(
        .FADE_STEPS (FADE_STEPS)
    ) u_shade (
        .i_loc          (r_loc),
        .i_step         (r_step),
        .i_second_color (r_second_color),
        .o_color        (n_color)
    );

`ifndef NO_ASSERTIONS
    // a held middle stage keeps its contents
    a_loc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loc_valid && !rdy_out |=> r_loc_valid && $stable(r_loc) && $stable(r_step))
        else $error("locate stage changed while stalled");

    // fade step never reaches FADE_STEPS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loc_valid |-> (32'(r_step) <= 32'(FADE_STEPS - 1)))
        else $error("fade step out of range");

    // input only backs up when every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_loc_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stalled with an empty stage");

    // an accepted item reaches the locate stage on the next edge when unblocked
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && rdy_loc |=> r_loc_valid)
        else $error("item lost between stages");
`endif

endmodule

>>> src/lrcf_locate.sv
`timescale 1ns / 1ps

module lrcf_locate #(
    parameter int FADE_STEPS = lrcf_pkg::DEF_FADE_STEPS,
    localparam int STEP_W = (FADE_STEPS > 1) ? $clog2(FADE_STEPS) : 1
) (
    input  logic [lrcf_pkg::HOUR_W-1:0]  i_hour,
    input  logic [lrcf_pkg::POS_W-1:0]   i_minute,
    input  logic [lrcf_pkg::POS_W-1:0]   i_second,
    input  logic [lrcf_pkg::MS_W-1:0]    i_milli,
    input  logic [lrcf_pkg::POS_W-1:0]   i_pixel,
    input  logic [lrcf_pkg::COLOR_W-1:0] i_minute_color,
    input  logic [lrcf_pkg::COLOR_W-1:0] i_hour_color,
    input  logic [lrcf_pkg::COLOR_W-1:0] i_hour_trail_color,
    input  logic                         i_mount_bottom,
    output lrcf_pkg::t_loc               o_loc,
    output logic [STEP_W-1:0]            o_step
);
    import lrcf_pkg::*;

    // step = floor(ms * F / 1000) as ms * ceil(F * 2^S / 1000) >> S
    localparam longint STEP_MUL =
        (longint'(FADE_STEPS) * (longint'(1) << RECIP_SHIFT) + longint'(MS_PER_SEC) - 1)
        / longint'(MS_PER_SEC);
    localparam int STEP_MUL_W = $clog2(STEP_MUL + 1);
    localparam int PROD_W     = MS_W + STEP_MUL_W;

    logic [3:0]        h12;
    logic [POS_W-1:0]  m60, s60;
    logic [6:0]        hraw;
    logic [POS_W-1:0]  hp, mp, sp, dh, ds;
    logic              on_hour, on_min, near_hour;
    logic [COLOR_W-1:0] color;
    t_sec_kind         kind;
    logic [PROD_W-1:0] prod, raw;

    always_comb begin
        if (i_hour >= 5'd24) begin
            h12 = 4'(i_hour - 5'd24);
        end else if (i_hour >= 5'(HOURS_HALF)) begin
            h12 = 4'(i_hour - 5'(HOURS_HALF));
        end else begin
            h12 = i_hour[3:0];
        end
        m60  = ring_wrap(7'(i_minute));
        s60  = ring_wrap(7'(i_second));
        // (60h + m + 6) / 12 = 5h + (m + 6) / 12, at most 60
        hraw = 7'(h12) * 7'd5 + 7'(div12(7'(m60) + 7'd6));
        hp   = ring_place(ring_wrap(hraw), i_mount_bottom);
        mp   = ring_place(m60, i_mount_bottom);
        sp   = ring_place(s60, i_mount_bottom);
        dh   = ring_dist(i_pixel, hp);
        ds   = ring_dist(i_pixel, sp);

        on_hour   = (i_pixel == hp);
        on_min    = (i_pixel == mp);
        near_hour = (dh == 6'd1) || (dh == 6'(RING_PIXELS - 1));

        color = '0;
        if (on_min) begin
            color = i_minute_color;
        end
        if (on_hour) begin
            color = i_hour_color;
        end else if (near_hour && (color == '0)) begin
            color = i_hour_trail_color;
        end

        kind = SEC_NONE;
        if (!on_hour && !on_min) begin
            if (ds == 6'd0) begin
                kind = SEC_DOT;
            end else if (ds == 6'd2) begin
                kind = SEC_AHEAD2;
            end else if (ds == 6'd1) begin
                kind = SEC_AHEAD1;
            end else if (ds == 6'(RING_PIXELS - 1)) begin
                kind = SEC_BEHIND1;
            end else if (ds == 6'(RING_PIXELS - 2)) begin
                kind = SEC_BEHIND2;
            end
        end

        // positions 60..63 are off the ring: black, no second hand
        if (i_pixel >= 6'(RING_PIXELS)) begin
            color = '0;
            kind  = SEC_NONE;
        end
    end

    assign o_loc = '{base: color, kind: kind};

    // fade step, saturating for ms beyond 999
    assign prod = PROD_W'(i_milli) * PROD_W'(STEP_MUL);
    assign raw  = prod >> RECIP_SHIFT;
    assign o_step = (raw >= PROD_W'(FADE_STEPS)) ? STEP_W'(FADE_STEPS - 1) : raw[STEP_W-1:0];

endmodule

>>> src/lrcf_shade.sv
`timescale 1ns / 1ps

module lrcf_shade #(
    parameter int FADE_STEPS = lrcf_pkg::DEF_FADE_STEPS,
    localparam int STEP_W = (FADE_STEPS > 1) ? $clog2(FADE_STEPS) : 1
) (
    input  lrcf_pkg::t_loc               i_loc,
    input  logic [STEP_W-1:0]            i_step,
    input  logic [lrcf_pkg::COLOR_W-1:0] i_second_color,
    output logic [lrcf_pkg::COLOR_W-1:0] o_color
);
    import lrcf_pkg::*;

    // step * span / F as step * ceil(span * 2^S / F) >> S; exact for step < F <= 1000
    localparam longint MUL_FAR =
        (longint'(SPAN_FAR) * (longint'(1) << RECIP_SHIFT) + longint'(FADE_STEPS) - 1)
        / longint'(FADE_STEPS);
    localparam longint MUL_NEAR =
        (longint'(SPAN_NEAR) * (longint'(1) << RECIP_SHIFT) + longint'(FADE_STEPS) - 1)
        / longint'(FADE_STEPS);
    localparam int FAR_W  = STEP_W + $clog2(MUL_FAR + 1);
    localparam int NEAR_W = STEP_W + $clog2(MUL_NEAR + 1);

    logic [FAR_W-1:0]  prod_far;
    logic [NEAR_W-1:0] prod_near;
    logic [6:0]        q_far, q_near;

    assign prod_far  = FAR_W'(i_step) * FAR_W'(MUL_FAR);
    assign prod_near = NEAR_W'(i_step) * NEAR_W'(MUL_NEAR);
    assign q_far     = prod_far[RECIP_SHIFT +: 7];
    assign q_near    = prod_near[RECIP_SHIFT +: 7];

    always_comb begin
        case (i_loc.kind)
            SEC_NONE:    o_color = i_loc.base;
            SEC_DOT:     o_color = i_second_color;
            SEC_AHEAD2:  o_color = cyan(8'(SHADE_FAR_LO) + 8'(q_far));
            SEC_AHEAD1:  o_color = cyan(8'(SHADE_MID) + 8'(q_near));
            SEC_BEHIND1: o_color = cyan(8'(SHADE_FULL) - 8'(q_near));
            SEC_BEHIND2: o_color = cyan(8'(SHADE_MID) - 8'(q_far));
            default:     o_color = i_loc.base;
        endcase
    end

endmodule
